>>> sv/csqw_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the semaphore wait queue modules
// no dependencies
package csqw_pkg;

  localparam logic [1:0] OP_WAIT   = 2'd0;
  localparam logic [1:0] OP_SIGNAL = 2'd1;
  localparam logic [1:0] OP_SWAP   = 2'd2;

  localparam logic signed [7:0] COUNT_RST = 8'sd1;
  localparam logic signed [8:0] COUNT_MAX = 9'sd127;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] caller_id;
  } csqw_req_t;

  typedef struct packed {
    logic              caller_blocks;
    logic              wake_valid;
    logic [7:0]        wake_thread;
    logic              queue_overflow;
    logic signed [7:0] count_now;
    logic [3:0]        waiters;
  } csqw_rsp_t;

  // one queue slot: waiting thread and its deferred decrement mark
  typedef struct packed {
    logic [7:0] id;
    logic       pend;
  } csqw_entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } csqw_cell_ctl_t;

endpackage

>>> sv/csqw_cell.sv
`timescale 1ns / 1ps
// one slot of the shifting wait queue
// depends on csqw_pkg
module csqw_cell
  import csqw_pkg::*;
(
  input  logic           clk,
  input  csqw_cell_ctl_t ctl,
  input  csqw_entry_t    nbr,
  input  csqw_entry_t    wr,
  output csqw_entry_t    q
);

  csqw_entry_t slot_r;

  // a new entry wins over the shift from the neighbor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot_r <= wr;
    end else if (ctl.shift) begin
      slot_r <= nbr;
    end
  end

  assign q = slot_r;

endmodule

>>> sv/counting_semaphore_wait_queue_top.sv
`timescale 1ns / 1ps
// counting semaphore with a fifo of waiting thread ids, top level
// depends on csqw_pkg and csqw_cell
//
// usage:
//   in channel (in_valid/in_ready/in_req) takes one request word: wait,
//   signal or signal-and-swap with the caller's thread id
//   out channel (out_valid/out_ready/out_rsp) returns one response word per
//   request: block flag, woken thread, overflow flag, count and queue fill
//   cfg_we/cfg_wdata loads the count and empties the queue; write it only
//   while no request is in flight
// timing: a request is decided in the cycle it is accepted and its response
//   is captured in the output register at the accepting clock edge; one request
//   per cycle is sustained while out_ready stays high, set by the single count
//   update and the shift of the cell row (head always sits in cell 0)
// reset: count returns to 1, the queue is empty, no response is pending
// stall: while out_ready is low a held response keeps in_ready low; a new
//   request is taken in the same cycle the held response leaves
module counting_semaphore_wait_queue_top
  import csqw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  csqw_req_t         in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output csqw_rsp_t         out_rsp,
  input  logic              cfg_we,
  input  logic signed [7:0] cfg_wdata
);

  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_L = OW'(QUEUE_DEPTH);

  logic signed [7:0] count_r, count_nxt;
  logic [OW-1:0]     occ_r, occ_nxt;
  logic              out_valid_r;
  csqw_rsp_t         out_rsp_r, rsp_nxt;

  logic              accept;
  logic              shift_en, load_en;
  logic [OW-1:0]     load_idx;
  csqw_entry_t       wr_entry;
  logic signed [8:0] sum;

  csqw_entry_t       cell_q [QUEUE_DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    shift_en  = 1'b0;
    load_en   = 1'b0;
    load_idx  = occ_r;
    wr_entry  = '{id: in_req.caller_id, pend: 1'b0};
    count_nxt = count_r;
    occ_nxt   = occ_r;
    sum       = 9'(count_r) + 9'sd1;
    rsp_nxt   = '0;
    case (in_req.op)
      OP_WAIT: begin
        if (count_r > 8'sd0) begin
          count_nxt = count_r - 8'sd1;
        end else if (occ_r != DEPTH_L) begin
          load_en       = 1'b1;
          wr_entry.pend = 1'b1;
          occ_nxt       = occ_r + 1'b1;
          rsp_nxt.caller_blocks = 1'b1;
        end else begin
          rsp_nxt.queue_overflow = 1'b1;
        end
      end
      OP_SIGNAL, OP_SWAP: begin
        if (occ_r != '0) begin
          shift_en            = 1'b1;
          rsp_nxt.wake_valid  = 1'b1;
          rsp_nxt.wake_thread = cell_q[0].id;
          sum                 = sum - 9'(cell_q[0].pend);
          occ_nxt             = occ_r - 1'b1;
          // swap refills the slot just freed at the tail
          if (in_req.op == OP_SWAP) begin
            load_en  = 1'b1;
            load_idx = occ_r - 1'b1;
            occ_nxt  = occ_r;
            rsp_nxt.caller_blocks = 1'b1;
          end
        end
        count_nxt = (sum > COUNT_MAX) ? COUNT_MAX[7:0] : sum[7:0];
      end
      default: begin
      end
    endcase
    rsp_nxt.count_now = count_nxt;
    rsp_nxt.waiters   = 4'(occ_nxt);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    csqw_cell_ctl_t ctl;
    csqw_entry_t    nbr;
    assign ctl.shift = accept && shift_en;
    assign ctl.load  = accept && load_en && (load_idx == OW'(i));
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr = wr_entry;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    csqw_cell u_cell (
      .clk (clk),
      .ctl (ctl),
      .nbr (nbr),
      .wr  (wr_entry),
      .q   (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RST;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
        occ_r   <= '0;
      end else if (accept) begin
        count_r <= count_nxt;
        occ_r   <= occ_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
